@@ src/hes_pkg.sv @@
package hes_pkg;

	localparam int unsigned NodeCount = 19;

	localparam logic [4:0] NODE_IDLE  = 5'd0;
	localparam logic [4:0] NODE_AMP   = 5'd1;
	localparam logic [4:0] NODE_A     = 5'd2;
	localparam logic [4:0] NODE_AM    = 5'd3;
	localparam logic [4:0] NODE_AMPP  = 5'd4;
	localparam logic [4:0] NODE_L     = 5'd5;
	localparam logic [4:0] NODE_LT    = 5'd6;
	localparam logic [4:0] NODE_G     = 5'd7;
	localparam logic [4:0] NODE_GT    = 5'd8;
	localparam logic [4:0] NODE_Q     = 5'd9;
	localparam logic [4:0] NODE_QU    = 5'd10;
	localparam logic [4:0] NODE_QUO   = 5'd11;
	localparam logic [4:0] NODE_QUOT  = 5'd12;
	localparam logic [4:0] NODE_HASH  = 5'd13;
	localparam logic [4:0] NODE_HX    = 5'd14;
	localparam logic [4:0] NODE_HX2   = 5'd15;
	localparam logic [4:0] NODE_HX27  = 5'd16;
	localparam logic [4:0] NODE_H3    = 5'd17;
	localparam logic [4:0] NODE_H39   = 5'd18;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_SEMI = 8'h3b;
	localparam logic [7:0] CH_HASH = 8'h23;

	typedef logic [4:0] node_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       hit;
		logic       emit;
		logic [7:0] emit_byte;
		node_t      to;
	} step_t;

	typedef struct packed {
		node_t      node;
		logic       has_extra;
		logic [7:0] extra;
		logic       last;
		logic [2:0] count;
	} burst_t;

	function automatic logic [2:0] node_len(input node_t n);
		logic [2:0] len;
		unique case (n)
			NODE_AMP: len = 3'd1;
			NODE_A, NODE_L, NODE_G, NODE_Q, NODE_HASH: len = 3'd2;
			NODE_AM, NODE_LT, NODE_GT, NODE_QU, NODE_HX, NODE_H3: len = 3'd3;
			NODE_AMPP, NODE_QUO, NODE_HX2, NODE_H39: len = 3'd4;
			NODE_QUOT, NODE_HX27: len = 3'd5;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	function automatic logic [39:0] node_text(input node_t n);
		logic [39:0] t;
		unique case (n)
			NODE_AMP:  t = {"&", 32'h0};
			NODE_A:    t = {"&a", 24'h0};
			NODE_AM:   t = {"&am", 16'h0};
			NODE_AMPP: t = {"&amp", 8'h0};
			NODE_L:    t = {"&l", 24'h0};
			NODE_LT:   t = {"&lt", 16'h0};
			NODE_G:    t = {"&g", 24'h0};
			NODE_GT:   t = {"&gt", 16'h0};
			NODE_Q:    t = {"&q", 24'h0};
			NODE_QU:   t = {"&qu", 16'h0};
			NODE_QUO:  t = {"&quo", 8'h0};
			NODE_QUOT: t = "&quot";
			NODE_HASH: t = {"&#", 24'h0};
			NODE_HX:   t = {"&#x", 16'h0};
			NODE_HX2:  t = {"&#x2", 8'h0};
			NODE_HX27: t = "&#x27";
			NODE_H3:   t = {"&#3", 16'h0};
			NODE_H39:  t = {"&#39", 8'h0};
			default:   t = 40'h0;
		endcase
		return t;
	endfunction

	function automatic logic [7:0] node_char(input node_t n, input logic [2:0] idx);
		logic [39:0] t;
		logic [7:0]  c;
		t = node_text(n);
		unique case (idx)
			3'd0: c = t[39:32];
			3'd1: c = t[31:24];
			3'd2: c = t[23:16];
			3'd3: c = t[15:8];
			3'd4: c = t[7:0];
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic step_t trie_step(input node_t cur, input logic [7:0] b);
		step_t s;
		s = '{hit: 1'b0, emit: 1'b0, emit_byte: 8'h00, to: NODE_IDLE};
		unique case (cur)
			NODE_IDLE: if (b == CH_AMP) s = '{1'b1, 1'b0, 8'h00, NODE_AMP};
			NODE_AMP: begin
				if (b == "a")          s = '{1'b1, 1'b0, 8'h00, NODE_A};
				else if (b == "l")     s = '{1'b1, 1'b0, 8'h00, NODE_L};
				else if (b == "g")     s = '{1'b1, 1'b0, 8'h00, NODE_G};
				else if (b == "q")     s = '{1'b1, 1'b0, 8'h00, NODE_Q};
				else if (b == CH_HASH) s = '{1'b1, 1'b0, 8'h00, NODE_HASH};
			end
			NODE_A:    if (b == "m") s = '{1'b1, 1'b0, 8'h00, NODE_AM};
			NODE_AM:   if (b == "p") s = '{1'b1, 1'b0, 8'h00, NODE_AMPP};
			NODE_AMPP: if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_AMP, NODE_IDLE};
			NODE_L:    if (b == "t") s = '{1'b1, 1'b0, 8'h00, NODE_LT};
			NODE_LT:   if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_LT, NODE_IDLE};
			NODE_G:    if (b == "t") s = '{1'b1, 1'b0, 8'h00, NODE_GT};
			NODE_GT:   if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_GT, NODE_IDLE};
			NODE_Q:    if (b == "u") s = '{1'b1, 1'b0, 8'h00, NODE_QU};
			NODE_QU:   if (b == "o") s = '{1'b1, 1'b0, 8'h00, NODE_QUO};
			NODE_QUO:  if (b == "t") s = '{1'b1, 1'b0, 8'h00, NODE_QUOT};
			NODE_QUOT: if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_QUOT, NODE_IDLE};
			NODE_HASH: begin
				if (b == "x")      s = '{1'b1, 1'b0, 8'h00, NODE_HX};
				else if (b == "3") s = '{1'b1, 1'b0, 8'h00, NODE_H3};
			end
			NODE_HX:   if (b == "2") s = '{1'b1, 1'b0, 8'h00, NODE_HX2};
			NODE_HX2:  if (b == "7") s = '{1'b1, 1'b0, 8'h00, NODE_HX27};
			NODE_HX27: if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_APOS, NODE_IDLE};
			NODE_H3:   if (b == "9") s = '{1'b1, 1'b0, 8'h00, NODE_H39};
			NODE_H39:  if (b == CH_SEMI) s = '{1'b1, 1'b1, CH_APOS, NODE_IDLE};
			default: ;
		endcase
		return s;
	endfunction

endpackage

@@ src/hes_if.sv @@
interface hes_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface hes_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

@@ src/html_entity_unescape_stream_unit.sv @@
// HTML entity unescaper for a byte stream.
// escaped: sink channel, one beat per byte of escaped text (in_byte), with
//   in_last set on the final byte of a text.
// plain: source channel, one beat per byte of unescaped text (out_byte), with
//   out_last set on the final beat of a text.
// &amp; &lt; &gt; &quot; &#x27; &#39; decode to one byte; any other partial
// entity is replayed literally once it fails or the text ends.
// An accepted byte is held in the input register, then loaded into the
// output serializer that drives plain. Throughput: one input byte per
// cycle while plain is ready and each byte yields at most one output beat;
// a byte that flushes a held prefix yields up to six beats and holds the
// serializer until all are sent. Bytes held in a prefix produce no beat.
// The input register keeps accepting one byte while plain is stalled; after
// that escaped.ready drops until the serializer drains.
// Reset clears the match state to idle and empties both stages.
module html_entity_unescape_stream_unit (
	input  logic      clk,
	input  logic      arst_n,
	hes_in_if.sink    escaped,
	hes_out_if.source plain
);

	logic            valid_s1;
	hes_pkg::item_t  item_s1;
	hes_pkg::burst_t burst;
	logic            free;
	logic            take;

	assign take = valid_s1 && free;

	hes_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.escaped  (escaped),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	hes_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.burst  (burst)
	);

	hes_burst u_burst (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take),
		.burst  (burst),
		.free   (free),
		.plain  (plain)
	);

endmodule

@@ src/hes_in_stage.sv @@
module hes_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	hes_in_if.sink         escaped,
	input  logic           take,
	output logic           valid_s1,
	output hes_pkg::item_t item_s1
);

	assign escaped.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (escaped.ready) begin
			valid_s1 <= escaped.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (escaped.valid && escaped.ready) begin
			item_s1 <= '{data: escaped.in_byte, last: escaped.in_last};
		end
	end

endmodule

@@ src/hes_decode.sv @@
module hes_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  hes_pkg::item_t  item,
	output hes_pkg::burst_t burst
);

	hes_pkg::node_t match_q;
	hes_pkg::node_t cur;
	hes_pkg::node_t nxt;
	hes_pkg::step_t st;

	assign cur = (match_q < 5'(hes_pkg::NodeCount)) ? match_q : hes_pkg::NODE_IDLE;
	assign st  = hes_pkg::trie_step(cur, item.data);

	always_comb begin
		burst.node      = hes_pkg::NODE_IDLE;
		burst.has_extra = 1'b0;
		burst.extra     = item.data;
		burst.last      = item.last;
		nxt             = hes_pkg::NODE_IDLE;
		if (st.hit && st.emit) begin
			burst.has_extra = 1'b1;
			burst.extra     = st.emit_byte;
		end else if (st.hit) begin
			if (item.last) begin
				burst.node = st.to;
			end else begin
				nxt = st.to;
			end
		end else begin
			burst.node = cur;
			if (item.data == hes_pkg::CH_AMP && !item.last) begin
				nxt = hes_pkg::NODE_AMP;
			end else begin
				burst.has_extra = 1'b1;
			end
		end
		burst.count = hes_pkg::node_len(burst.node) + {2'b00, burst.has_extra};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= hes_pkg::NODE_IDLE;
		end else if (take) begin
			match_q <= nxt;
		end
	end

endmodule

@@ src/hes_burst.sv @@
module hes_burst (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  hes_pkg::burst_t burst,
	output logic            free,
	hes_out_if.source       plain
);

	logic            valid_q;
	logic [2:0]      idx_q;
	hes_pkg::burst_t cur_q;
	logic            final_beat;

	assign final_beat     = (idx_q == cur_q.count - 3'd1);
	assign free           = !valid_q || (plain.ready && final_beat);
	assign plain.valid    = valid_q;
	assign plain.out_byte = (idx_q < hes_pkg::node_len(cur_q.node))
		? hes_pkg::node_char(cur_q.node, idx_q) : cur_q.extra;
	assign plain.out_last = cur_q.last && final_beat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= (burst.count != 3'd0);
			idx_q   <= 3'd0;
		end else if (valid_q && plain.ready) begin
			if (final_beat) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end else if (free) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= burst;
		end
	end

endmodule
